[rtl/core/scn_pkg.sv]
// Package for the start-code NAL splitter: widths, NAL type codes, class codes
// and the structs that pass between the step logic and the result buffer.
// Has no dependencies of its own.
package scn_pkg;

  // Width of the running unit length counter, which saturates.
  localparam int LENGTH_BITS    = 24;
  // Width of the reported unit length field.
  localparam int LEN_FIELD_BITS = 24;

  localparam logic [LENGTH_BITS-1:0] LEN_COUNT_MAX   = '1;
  localparam logic [31:0]            LEN_FIELD_MAX32 = 32'((64'd1 << LEN_FIELD_BITS) - 64'd1);

  // Final byte of the start code, and the number of zeros held back at most.
  localparam logic [7:0] START_CODE_LAST = 8'h01;
  localparam logic [1:0] HELD_MAX        = 2'd3;

  localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_SPS   = 2'd1,
    CLS_PPS   = 2'd2,
    CLS_IDR   = 2'd3
  } unit_class_t;

  typedef logic [LENGTH_BITS-1:0] len_cnt_t;

  // Splitter state. The held bytes are always zeros, so only their count is kept.
  typedef struct packed {
    logic [1:0] held_cnt;
    len_cnt_t   len_cnt;
    logic       len_over;
    logic [4:0] cur_type;
  } split_state_t;

  // All results caused by one item, in compact form: a run of zero payload
  // bytes, then optionally the item's own byte, then optionally a descriptor.
  typedef struct packed {
    logic [2:0]                 n_res;
    logic [2:0]                 n_zero;
    logic                       has_byte;
    logic [7:0]                 data_b;
    logic                       first;
    logic [LEN_FIELD_BITS-1:0]  desc_len;
    logic [4:0]                 desc_type;
    unit_class_t                desc_cls;
    logic                       desc_sat;
  } run_t;

endpackage

[rtl/core/scn_step.sv]
// Step logic of the start-code NAL splitter: from the current state and one
// input item, works out the next state and the compact run of results.
// Depends on scn_pkg.
module scn_step (
  input  logic [7:0]           data_byte,
  input  logic                 end_of_buffer,
  input  scn_pkg::split_state_t st,
  output scn_pkg::split_state_t st_nxt,
  output scn_pkg::run_t        run
);
  import scn_pkg::*;

  logic                     is_zero;
  logic                     is_start;
  logic [2:0]               n_zero;
  logic                     has_byte;
  logic                     close_req;
  logic [1:0]               held_nxt;
  logic [2:0]               pay_cnt;
  logic [LENGTH_BITS:0]     len_sum;
  logic                     over_hit;
  len_cnt_t                 len_acc;
  logic                     over_acc;
  logic                     first;
  logic [4:0]               type_acc;
  logic                     close_emit;
  logic [31:0]              len_wide;
  logic                     len_clamp;
  unit_class_t              cls;

  always_comb begin
    is_zero  = (data_byte == 8'h00);
    is_start = (data_byte == START_CODE_LAST) && (st.held_cnt == HELD_MAX);

    if (is_zero) begin
      has_byte  = 1'b0;
      close_req = end_of_buffer;
      if (end_of_buffer) begin
        // The new zero joins the held ones and all of them are flushed.
        n_zero   = 3'({1'b0, st.held_cnt}) + 3'd1;
        held_nxt = 2'd0;
      end else if (st.held_cnt == HELD_MAX) begin
        // A fourth zero in a row: the oldest one cannot begin the start code.
        n_zero   = 3'd1;
        held_nxt = HELD_MAX;
      end else begin
        n_zero   = 3'd0;
        held_nxt = st.held_cnt + 2'd1;
      end
    end else if (is_start) begin
      n_zero    = 3'd0;
      has_byte  = 1'b0;
      close_req = 1'b1;
      held_nxt  = 2'd0;
    end else begin
      n_zero    = 3'({1'b0, st.held_cnt});
      has_byte  = 1'b1;
      close_req = end_of_buffer;
      held_nxt  = 2'd0;
    end

    pay_cnt  = n_zero + 3'({2'b00, has_byte});
    len_sum  = {1'b0, st.len_cnt} + (LENGTH_BITS+1)'(pay_cnt);
    over_hit = len_sum[LENGTH_BITS];
    len_acc  = over_hit ? LEN_COUNT_MAX : len_sum[LENGTH_BITS-1:0];
    over_acc = st.len_over | over_hit;

    // Only the first payload byte of this item can open a unit.
    first    = (st.len_cnt == '0) && !st.len_over && (pay_cnt != 3'd0);
    if (first) begin
      type_acc = (n_zero != 3'd0) ? 5'd0 : data_byte[4:0];
    end else begin
      type_acc = st.cur_type;
    end

    close_emit = close_req && ((len_acc != '0) || over_acc);

    len_wide  = 32'(len_acc);
    len_clamp = (len_wide > LEN_FIELD_MAX32);

    case (type_acc)
      NAL_TYPE_SPS: cls = CLS_SPS;
      NAL_TYPE_PPS: cls = CLS_PPS;
      NAL_TYPE_IDR: cls = CLS_IDR;
      default:      cls = CLS_OTHER;
    endcase

    run.n_res     = pay_cnt + 3'({2'b00, close_emit});
    run.n_zero    = n_zero;
    run.has_byte  = has_byte;
    run.data_b    = data_byte;
    run.first     = first;
    run.desc_len  = len_clamp ? '1 : len_wide[LEN_FIELD_BITS-1:0];
    run.desc_type = type_acc;
    run.desc_cls  = cls;
    run.desc_sat  = over_acc | len_clamp;

    st_nxt.held_cnt = held_nxt;
    st_nxt.len_cnt  = close_req ? '0 : len_acc;
    st_nxt.len_over = close_req ? 1'b0 : over_acc;
    st_nxt.cur_type = type_acc;
  end

endmodule

[rtl/core/scn_run_buf.sv]
// Result buffer of the start-code NAL splitter: holds the run of results of
// one item and hands them out one per cycle unless out_stall holds them. Depends on scn_pkg.
module scn_run_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  scn_pkg::run_t        run_in,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [7:0]           out_payload_byte,
  output logic                 out_first_of_unit,
  output logic [23:0]          out_unit_length,
  output logic [4:0]           out_unit_type,
  output scn_pkg::unit_class_t out_unit_class,
  output logic                 out_length_saturated,
  output logic                 out_last_of_run
);
  import scn_pkg::*;

  run_t       run_r;
  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;
  logic [2:0] idx_r;
  logic [2:0] idx_nxt;
  logic [2:0] idx_inc;
  logic       pop;

  assign idx_inc   = idx_r + 3'd1;
  assign out_valid = (idx_r != cnt_r);
  assign pop       = out_valid && !out_stall;
  assign free      = !out_valid || (pop && (idx_inc == cnt_r));

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = run_in.n_res;
      idx_nxt = 3'd0;
    end else if (pop) begin
      idx_nxt = idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run_in;
    end
  end

  always_comb begin
    out_kind             = 1'b0;
    out_payload_byte     = 8'h00;
    out_first_of_unit    = 1'b0;
    out_unit_length      = '0;
    out_unit_type        = 5'd0;
    out_unit_class       = CLS_OTHER;
    out_length_saturated = 1'b0;
    if (idx_r < run_r.n_zero) begin
      out_first_of_unit = (idx_r == 3'd0) && run_r.first;
    end else if ((idx_r == run_r.n_zero) && run_r.has_byte) begin
      out_payload_byte  = run_r.data_b;
      out_first_of_unit = (idx_r == 3'd0) && run_r.first;
    end else begin
      out_kind             = 1'b1;
      out_unit_length      = run_r.desc_len;
      out_unit_type        = run_r.desc_type;
      out_unit_class       = run_r.desc_cls;
      out_length_saturated = run_r.desc_sat;
    end
    out_last_of_run = (idx_inc == cnt_r);
  end

endmodule

[rtl/core/start_code_nal_splitter_unit.sv]
// Top level of the start-code NAL splitter: input register, splitter state
// and instances of the step logic and result buffer. Depends on scn_pkg,
// scn_step and scn_run_buf.
//
// Usage: one byte of an Annex-B buffer enters per item on the in_ channel,
// with in_end_of_buffer set on the buffer's final byte. The out_ channel gives
// payload bytes (out_kind 0, first byte of each unit marked) and one
// descriptor (out_kind 1) closing each non-empty unit with its length, NAL
// type, class and a saturation flag. out_last_of_run marks the last result
// caused by one input byte; a byte that is only held back causes none.
// The first result of an item is offered once its run is in the run buffer.
// Throughput: one item per cycle while each item causes at most one result
// and the receiver does not stall; an item causing more results, at most five,
// holds the result stage until all have left. The limit is the single result
// port draining the run buffer. When the receiver stalls, the current result
// holds still, one further item waits in the input register and then in_stall
// rises. A synchronous reset empties both stages and clears the held zeros and
// unit length.
module start_code_nal_splitter_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_end_of_buffer,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [7:0]           out_payload_byte,
  output logic                 out_first_of_unit,
  output logic [23:0]          out_unit_length,
  output logic [4:0]           out_unit_type,
  output scn_pkg::unit_class_t out_unit_class,
  output logic                 out_length_saturated,
  output logic                 out_last_of_run
);
  import scn_pkg::*;

  logic         in_vld_r;
  logic         in_vld_nxt;
  logic [7:0]   in_data_r;
  logic         in_eob_r;
  split_state_t st_r;
  split_state_t st_nxt;
  run_t         run;
  logic         free;
  logic         load;
  logic         take;

  assign load     = in_vld_r && free;
  assign in_stall = in_vld_r && !free;
  assign take     = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take) begin
      in_vld_nxt = 1'b1;
    end else if (load) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (load) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_data_r <= in_data_byte;
      in_eob_r  <= in_end_of_buffer;
    end
  end

  scn_step u_step (
    .data_byte     (in_data_r),
    .end_of_buffer (in_eob_r),
    .st            (st_r),
    .st_nxt        (st_nxt),
    .run           (run)
  );

  scn_run_buf u_run_buf (
    .clk                  (clk),
    .rst_n                (rst_n),
    .load                 (load),
    .run_in               (run),
    .free                 (free),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_payload_byte     (out_payload_byte),
    .out_first_of_unit    (out_first_of_unit),
    .out_unit_length      (out_unit_length),
    .out_unit_type        (out_unit_type),
    .out_unit_class       (out_unit_class),
    .out_length_saturated (out_length_saturated),
    .out_last_of_run      (out_last_of_run)
  );

endmodule
